[hw/rtl/sfr_pkg.sv]
package sfr_pkg;

  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 4;
  localparam int CFG_ADDR_W = 8;
  localparam int CFG_DATA_W = 64;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_FIND_LEN   = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FIND_BYTES = 8'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_REPL_LEN   = 8'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_REPL_BYTES = 8'd3;

  typedef enum logic {
    CMD_BYTES,
    CMD_REPL
  } cmd_kind_t;

  // control part of one command between front and back
  typedef struct packed {
    cmd_kind_t kind;
    logic      last;
  } sfr_cmd_t;

endpackage

[hw/rtl/sfr_if.sv]
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, in_byte, in_last, input ready);
  modport sink (input valid, in_byte, in_last, output ready);
endinterface

interface sfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  modport source (output valid, out_byte, out_last, input ready);
  modport sink (input valid, out_byte, out_last, output ready);
endinterface

interface sfr_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  addr;
  logic [63:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

[hw/rtl/stream_find_replace.sv]
// Streaming find-and-replace: every non-overlapping, leftmost-first occurrence of the
// configured pattern (find_len bytes, 1..MAX_PATTERN) in the byte stream is replaced by
// repl_len replacement bytes; in_last flushes the held bytes and marks the final output
// byte with out_last. The front end takes one byte per cycle into a hold-back window,
// compares it against the pattern and queues at most one command per byte (emit the
// oldest byte, emit the replacement, or flush the window); the back end sends one
// output byte per cycle while out_ready is high. Without matches the block sustains
// one byte in and one out per cycle; a match emits repl_len output bytes and a final
// flush up to find_len, and the input stalls once the two-entry command queue
// fills, so the output port sets the rate. Write configuration only while the block is
// idle; writing find_len discards any bytes held in the window.
module stream_find_replace import sfr_pkg::*; #(
  parameter int MAX_PATTERN     = 8,
  parameter int MAX_REPLACEMENT = 8
) (
  input logic       clk,
  input logic       rst,
  sfr_in_if.sink    in_ch,
  sfr_out_if.source out_ch,
  sfr_cfg_if.sink   cfg
);

  localparam int CW = $clog2(MAX_PATTERN + 1);
  localparam int RW = $clog2(MAX_REPLACEMENT + 1);
  localparam int EW = (CW > RW) ? CW : RW;
  localparam int DW = $bits(sfr_cmd_t) + BYTE_W * MAX_PATTERN + CW;

  logic [LEN_W-1:0]      find_len;
  logic [CFG_DATA_W-1:0] find_bytes;
  logic [LEN_W-1:0]      repl_len;
  logic [CFG_DATA_W-1:0] repl_bytes;

  logic                              cfg_wr;
  logic [CW-1:0]                     flen;
  logic [RW-1:0]                     rlen;
  logic [BYTE_W*MAX_PATTERN-1:0]     find_ext;
  logic [BYTE_W*MAX_REPLACEMENT-1:0] repl_ext;

  logic                          push;
  logic                          q_full;
  sfr_cmd_t                      f_cmd;
  logic [BYTE_W*MAX_PATTERN-1:0] f_bytes;
  logic [CW-1:0]                 f_count;
  logic [CW-1:0]                 held;

  logic                          pop;
  logic                          q_valid;
  logic [DW-1:0]                 q_data;
  sfr_cmd_t                      q_cmd;
  logic [BYTE_W*MAX_PATTERN-1:0] q_bytes;
  logic [CW-1:0]                 q_count;

  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      find_len   <= LEN_W'(1);
      find_bytes <= '0;
      repl_len   <= LEN_W'(1);
      repl_bytes <= '0;
    end else if (cfg_wr) begin
      case (cfg.addr)
        REG_FIND_LEN:   find_len   <= cfg.data[LEN_W-1:0];
        REG_FIND_BYTES: find_bytes <= cfg.data;
        REG_REPL_LEN:   repl_len   <= cfg.data[LEN_W-1:0];
        REG_REPL_BYTES: repl_bytes <= cfg.data;
        default: ;
      endcase
    end
  end

  // zero length acts as one; saturate at the maximum
  always_comb begin
    if (find_len == '0) begin
      flen = CW'(1);
    end else if (32'(find_len) > 32'(MAX_PATTERN)) begin
      flen = CW'(MAX_PATTERN);
    end else begin
      flen = CW'(find_len);
    end
    if (repl_len == '0) begin
      rlen = RW'(1);
    end else if (32'(repl_len) > 32'(MAX_REPLACEMENT)) begin
      rlen = RW'(MAX_REPLACEMENT);
    end else begin
      rlen = RW'(repl_len);
    end
  end

  // bytes beyond the eighth read as zero
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      find_ext[BYTE_W*i +: BYTE_W] = (i < 8) ? find_bytes[BYTE_W*(i % 8) +: BYTE_W] : '0;
    end
    for (int i = 0; i < MAX_REPLACEMENT; i++) begin
      repl_ext[BYTE_W*i +: BYTE_W] = (i < 8) ? repl_bytes[BYTE_W*(i % 8) +: BYTE_W] : '0;
    end
  end

  sfr_front #(
    .MAX_PATTERN (MAX_PATTERN),
    .CW          (CW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_byte   (in_ch.in_byte),
    .in_last   (in_ch.in_last),
    .in_ready  (in_ch.ready),
    .clear     (cfg_wr && cfg.addr == REG_FIND_LEN),
    .flen      (flen),
    .find_ext  (find_ext),
    .q_full    (q_full),
    .push      (push),
    .cmd       (f_cmd),
    .cmd_bytes (f_bytes),
    .cmd_count (f_count),
    .held      (held)
  );

  sfr_queue #(
    .DW (DW)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata ({f_cmd, f_bytes, f_count}),
    .full  (q_full),
    .pop   (pop),
    .valid (q_valid),
    .rdata (q_data)
  );

  assign {q_cmd, q_bytes, q_count} = q_data;

  sfr_back #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT),
    .CW              (CW),
    .RW              (RW),
    .EW              (EW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_bytes   (q_bytes),
    .q_count   (q_count),
    .pop       (pop),
    .rlen      (rlen),
    .repl_ext  (repl_ext),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .out_last  (out_ch.out_last)
  );

  a_held_below_flen: assert property (@(posedge clk) disable iff (rst)
    held < flen)
    else $error("window holds a full pattern between items");

  a_last_empties_window: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready && in_ch.in_last |=> held == '0)
    else $error("window not empty after last item");

  a_byte_cmd_count: assert property (@(posedge clk) disable iff (rst)
    q_valid && q_cmd.kind == CMD_BYTES |-> q_count != '0 && q_count <= flen)
    else $error("queued byte command with bad count");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !push)
    else $error("command pushed into full queue");

endmodule

[hw/rtl/sfr_front.sv]
module sfr_front import sfr_pkg::*; #(
  parameter int MAX_PATTERN = 8,
  parameter int CW          = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [BYTE_W-1:0]             in_byte,
  input  logic                          in_last,
  output logic                          in_ready,
  input  logic                          clear,
  input  logic [CW-1:0]                 flen,
  input  logic [BYTE_W*MAX_PATTERN-1:0] find_ext,
  input  logic                          q_full,
  output logic                          push,
  output sfr_cmd_t                      cmd,
  output logic [BYTE_W*MAX_PATTERN-1:0] cmd_bytes,
  output logic [CW-1:0]                 cmd_count,
  output logic [CW-1:0]                 held
);

  logic [BYTE_W-1:0] win [MAX_PATTERN];
  logic [CW-1:0]     cnt;

  logic [BYTE_W-1:0] w_new [MAX_PATTERN];
  logic [CW-1:0]     cnt_new;
  logic              full;
  logic              match;
  logic              take;

  always_comb begin
    cnt_new = cnt + CW'(1);
    full    = (cnt_new == flen);
    match   = full;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      w_new[i] = (CW'(i) == cnt) ? in_byte : win[i];
      cmd_bytes[BYTE_W*i +: BYTE_W] = w_new[i];
      if (CW'(i) < flen && w_new[i] != find_ext[BYTE_W*i +: BYTE_W]) begin
        match = 1'b0;
      end
    end
  end

  assign in_ready = !q_full;
  assign take     = in_valid && !q_full;
  assign push     = take && (full || in_last);
  assign held     = cnt;

  always_comb begin
    cmd.last = in_last;
    if (match) begin
      cmd.kind  = CMD_REPL;
      cmd_count = flen;
    end else begin
      cmd.kind = CMD_BYTES;
      // a miss on a full window sends the oldest byte; the last item flushes all
      if (full && !in_last) begin
        cmd_count = CW'(1);
      end else begin
        cmd_count = cnt_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (clear) begin
      cnt <= '0;
    end else if (take) begin
      if (in_last || match) begin
        cnt <= '0;
      end else if (full) begin
        cnt <= flen - CW'(1);
      end else begin
        cnt <= cnt_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (full) begin
        // drop the oldest byte
        for (int i = 0; i < MAX_PATTERN - 1; i++) begin
          win[i] <= w_new[i + 1];
        end
      end else begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
          win[i] <= w_new[i];
        end
      end
    end
  end

endmodule

[hw/rtl/sfr_queue.sv]
module sfr_queue #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [DW-1:0] wdata,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;

  assign full  = (fill == 2'd2);
  assign valid = (fill != 2'd0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

[hw/rtl/sfr_back.sv]
module sfr_back import sfr_pkg::*; #(
  parameter int MAX_PATTERN     = 8,
  parameter int MAX_REPLACEMENT = 8,
  parameter int CW              = 4,
  parameter int RW              = 4,
  parameter int EW              = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  input  sfr_cmd_t                          q_cmd,
  input  logic [BYTE_W*MAX_PATTERN-1:0]     q_bytes,
  input  logic [CW-1:0]                     q_count,
  output logic                              pop,
  input  logic [RW-1:0]                     rlen,
  input  logic [BYTE_W*MAX_REPLACEMENT-1:0] repl_ext,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [BYTE_W-1:0]                 out_byte,
  output logic                              out_last
);

  logic                          cur_valid;
  sfr_cmd_t                      cur_cmd;
  logic [BYTE_W*MAX_PATTERN-1:0] cur_bytes;
  logic [CW-1:0]                 cur_count;
  logic [EW-1:0]                 idx;

  logic [EW-1:0] end_idx;
  logic          at_end;
  logic          done;

  assign end_idx = (cur_cmd.kind == CMD_REPL) ? EW'(rlen) : EW'(cur_count);
  assign at_end  = (idx == end_idx - EW'(1));
  assign done    = cur_valid && out_ready && at_end;
  assign pop     = q_valid && (!cur_valid || done);

  assign out_valid = cur_valid;
  assign out_last  = cur_cmd.last && at_end;

  always_comb begin
    out_byte = '0;
    if (cur_cmd.kind == CMD_REPL) begin
      for (int i = 0; i < MAX_REPLACEMENT; i++) begin
        if (EW'(i) == idx) begin
          out_byte = repl_ext[BYTE_W*i +: BYTE_W];
        end
      end
    end else begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        if (EW'(i) == idx) begin
          out_byte = cur_bytes[BYTE_W*i +: BYTE_W];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      cur_cmd   <= '{kind: CMD_BYTES, last: 1'b0};
      idx       <= '0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      cur_cmd   <= q_cmd;
      idx       <= '0;
    end else if (done) begin
      cur_valid <= 1'b0;
    end else if (cur_valid && out_ready) begin
      idx <= idx + EW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_bytes <= q_bytes;
      cur_count <= q_count;
    end
  end

endmodule

[dv/tb_stream_find_replace.sv]
`timescale 1ns / 100ps

module tb_stream_find_replace;
  import sfr_pkg::*;

  localparam int MAX_PAT      = 8;
  localparam int MAX_REP      = 8;
  localparam int SETTLE_WAIT  = 10;      // cycles after the last result before a register write
  localparam int DRAIN_LIMIT  = 20000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PRINT_LIMIT  = 40;
  localparam int RUN_LIMIT_NS = 2000000;

  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 8'hff;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } out_t;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] value;
    logic [BYTE_W-1:0]     b;
    logic                  l;
    bit                    typed;
    out_t                  want;
  } row_t;

  logic clk = 1'b0;
  logic rst;

  always #4 clk = ~clk;

  sfr_in_if  in_ch ();
  sfr_out_if out_ch ();
  sfr_cfg_if cfg ();

  stream_find_replace #(
    .MAX_PATTERN    (MAX_PAT),
    .MAX_REPLACEMENT(MAX_REP)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg   (cfg)
  );

  // shadow of the block: registers and hold-back window
  logic [LEN_W-1:0]      find_len_q;
  logic [CFG_DATA_W-1:0] find_pat;
  logic [LEN_W-1:0]      repl_len_q;
  logic [CFG_DATA_W-1:0] repl_pat;
  logic [BYTE_W-1:0]     win [MAX_PAT];
  int                    win_cnt;

  out_t burst [$];      // bytes caused by the item just accepted
  out_t due_bytes [$];  // rewritten bytes still to come out
  row_t script [$];

  logic [BYTE_W-1:0] alphabet [3];
  int  send_pct_q;
  int  recv_pct_q;
  int  items_sent;
  int  fail_count;
  bit  hold_req;

  function automatic bit coin(int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic int eff_len(logic [LEN_W-1:0] v, int max_len);
    if (v == 0) return 1;
    if (int'(v) > max_len) return max_len;
    return int'(v);
  endfunction

  function automatic void clear_model();
    int i;
    find_len_q = 1;
    find_pat   = '0;
    repl_len_q = 1;
    repl_pat   = '0;
    for (i = 0; i < MAX_PAT; i++) win[i] = '0;
    win_cnt = 0;
  endfunction

  function automatic void apply_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
    case (addr)
      REG_FIND_LEN: begin
        find_len_q = value[LEN_W-1:0];
        win_cnt = 0;
      end
      REG_FIND_BYTES: find_pat = value;
      REG_REPL_LEN: repl_len_q = value[LEN_W-1:0];
      REG_REPL_BYTES: repl_pat = value;
      default: ;
    endcase
  endfunction

  // one input byte through the window; results land in burst
  function automatic void rewrite_byte(logic [BYTE_W-1:0] b, logic l);
    int   flen;
    int   rlen;
    int   i;
    bit   hit;
    out_t o;
    flen = eff_len(find_len_q, MAX_PAT);
    rlen = eff_len(repl_len_q, MAX_REP);
    burst.delete();
    if (win_cnt >= flen) win_cnt = 0;
    win[win_cnt] = b;
    win_cnt++;
    if (win_cnt == flen) begin
      hit = 1'b1;
      for (i = 0; i < flen; i++)
        if (win[i] != find_pat[8*i +: 8]) hit = 1'b0;
      if (hit) begin
        for (i = 0; i < rlen; i++) begin
          o.data = repl_pat[8*i +: 8];
          o.last = 1'b0;
          burst.push_back(o);
        end
        win_cnt = 0;
      end else begin
        o.data = win[0];
        o.last = 1'b0;
        burst.push_back(o);
        for (i = 0; i + 1 < win_cnt; i++) win[i] = win[i+1];
        win_cnt--;
      end
    end
    if (l) begin
      for (i = 0; i < win_cnt; i++) begin
        o.data = win[i];
        o.last = 1'b0;
        burst.push_back(o);
      end
      win_cnt = 0;
      if (burst.size() > 0) begin
        o = burst.pop_back();
        o.last = 1'b1;
        burst.push_back(o);
      end
    end
  endfunction

  task automatic flag_mismatch(string msg);
    if (fail_count < PRINT_LIMIT) $display("mismatch: %s", msg);
    fail_count++;
  endtask

  task automatic check_output(logic [BYTE_W-1:0] b, logic l);
    out_t want;
    if (due_bytes.size() == 0) begin
      flag_mismatch($sformatf("unexpected byte %h last %b", b, l));
      return;
    end
    want = due_bytes.pop_front();
    if (b !== want.data) flag_mismatch($sformatf("out_byte %h, wanted %h", b, want.data));
    if (l !== want.last) flag_mismatch($sformatf("out_last %b, wanted %b (byte %h)",
                                                 l, want.last, want.data));
  endtask

  // offer one item, hold it until taken; valid stays high for the next item
  task automatic send_item(logic [BYTE_W-1:0] b, logic l, bit typed = 1'b0, out_t want = '0);
    int i;
    while (coin(send_pct_q)) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= l;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    rewrite_byte(b, l);
    if (typed) due_bytes.push_back(want);
    else for (i = 0; i < burst.size(); i++) due_bytes.push_back(burst[i]);
    items_sent++;
  endtask

  // drop valid and wait until every rewritten byte has come out
  task automatic settle();
    int waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    while (due_bytes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (due_bytes.size() != 0) begin
      flag_mismatch($sformatf("%0d bytes never came out", due_bytes.size()));
      due_bytes.delete();
    end
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  // leaves cfg.valid high; the caller lowers it after the last write
  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.addr  <= addr;
    cfg.data  <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    apply_reg(addr, value);
  endtask

  task automatic pick_config();
    logic [LEN_W-1:0]      fl;
    logic [LEN_W-1:0]      rl;
    logic [CFG_DATA_W-1:0] fp;
    logic [CFG_DATA_W-1:0] rp;
    logic [CFG_DATA_W-1:0] junk;
    int k;
    for (k = 0; k < 3; k++) alphabet[k] = BYTE_W'($urandom);
    fl = LEN_W'(coin(25) ? $urandom_range(15) : $urandom_range(1, 4));
    rl = LEN_W'(coin(25) ? $urandom_range(15) : $urandom_range(1, 4));
    fp = {$urandom, $urandom};
    rp = {$urandom, $urandom};
    // small alphabet so partial and overlapping matches are common
    if (!coin(15)) for (k = 0; k < 8; k++) fp[8*k +: 8] = alphabet[$urandom_range(2)];
    junk = {$urandom, $urandom};
    write_reg(REG_FIND_LEN, {junk[CFG_DATA_W-1:LEN_W], fl});
    write_reg(REG_FIND_BYTES, fp);
    junk = {$urandom, $urandom};
    write_reg(REG_REPL_LEN, {junk[CFG_DATA_W-1:LEN_W], rl});
    write_reg(REG_REPL_BYTES, rp);
    cfg.valid <= 1'b0;
  endtask

  task automatic send_stream(bit close);
    logic [BYTE_W-1:0] seq [$];
    logic [BYTE_W-1:0] tmp;
    int len;
    int flen;
    int k;
    flen = eff_len(find_len_q, MAX_PAT);
    len  = $urandom_range(1, 12);
    while (seq.size() < len) begin
      if (coin(30)) begin
        for (k = 0; k < flen; k++) seq.push_back(find_pat[8*k +: 8]);
      end else if (coin(80)) begin
        seq.push_back(alphabet[$urandom_range(2)]);
      end else begin
        tmp = BYTE_W'($urandom);
        seq.push_back(tmp);
      end
    end
    for (k = 0; k < seq.size(); k++) send_item(seq[k], close && (k == seq.size() - 1));
  endtask

  task automatic run_phase(int send_pct, int recv_pct, int quota, bit squeeze);
    int start;
    send_pct_q = send_pct;
    recv_pct_q = recv_pct;
    start = items_sent;
    while (items_sent - start < quota) begin
      settle();
      pick_config();
      if (squeeze) begin
        hold_req = 1'b1;
        squeeze  = 1'b0;
      end
      repeat ($urandom_range(1, 4)) send_stream(1'b1);
      // leave a stream open; the next pattern length write drops the window
      if (coin(25)) send_stream(1'b0);
    end
  endtask

  function automatic void add_cfg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.addr   = addr;
    r.value  = value;
    script.push_back(r);
  endfunction

  function automatic void add_data(logic [BYTE_W-1:0] b, logic l);
    row_t r;
    r = '{default: '0};
    r.b = b;
    r.l = l;
    script.push_back(r);
  endfunction

  function automatic void add_typed(logic [BYTE_W-1:0] b, logic l,
                                    logic [BYTE_W-1:0] eb, logic el);
    row_t r;
    r = '{default: '0};
    r.b         = b;
    r.l         = l;
    r.typed     = 1'b1;
    r.want.data = eb;
    r.want.last = el;
    script.push_back(r);
  endfunction

  // receiver: check results, stall at random, long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) check_output(out_ch.out_byte, out_ch.out_last);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !coin(recv_pct_q);
      end
    end
  end

  initial begin
    int k;
    bit cfg_open;
    rst           <= 1'b1;
    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= '0;
    in_ch.in_last <= 1'b0;
    cfg.valid     <= 1'b0;
    cfg.addr      <= '0;
    cfg.data      <= '0;
    send_pct_q = 0;
    recv_pct_q = 0;
    items_sent = 0;
    fail_count = 0;
    hold_req   = 1'b0;
    clear_model();

    // after reset: one-byte pattern 00 replaced by 00
    add_typed(8'h00, 1'b0, 8'h00, 1'b0);
    add_typed(8'hff, 1'b0, 8'hff, 1'b0);
    add_typed(8'h7f, 1'b1, 8'h7f, 1'b1);
    add_cfg(REG_UNUSED, '1);
    // zero lengths act as one
    add_cfg(REG_FIND_LEN, 64'd0);
    add_cfg(REG_FIND_BYTES, 64'h41);
    add_cfg(REG_REPL_LEN, 64'd0);
    add_cfg(REG_REPL_BYTES, 64'h5a);
    add_typed(8'h41, 1'b0, 8'h5a, 1'b0);
    add_typed(8'h42, 1'b1, 8'h42, 1'b1);
    // overlap: "aab" slides to "abc", then a flush of two
    add_cfg(REG_FIND_LEN, 64'd3);
    add_cfg(REG_FIND_BYTES, 64'h636261);
    add_cfg(REG_REPL_LEN, 64'd8);
    add_cfg(REG_REPL_BYTES, 64'hffeeddccbbaa9988);
    add_data(8'h61, 1'b0);
    add_data(8'h61, 1'b0);
    add_data(8'h62, 1'b0);
    add_data(8'h63, 1'b0);
    add_data(8'h61, 1'b0);
    add_data(8'h62, 1'b1);
    // lengths above the maximum saturate
    add_cfg(REG_FIND_LEN, 64'd15);
    add_cfg(REG_FIND_BYTES, '1);
    add_cfg(REG_REPL_LEN, 64'd9);
    add_cfg(REG_REPL_BYTES, 64'h0123456789abcdef);
    for (k = 0; k < 9; k++) add_data(8'hff, 1'b0);
    // pattern length rewritten with bytes held: they are dropped
    add_cfg(REG_FIND_LEN, 64'd2);
    add_cfg(REG_FIND_BYTES, 64'd0);
    add_cfg(REG_REPL_LEN, 64'd1);
    add_cfg(REG_REPL_BYTES, 64'h80);
    add_data(8'h00, 1'b0);
    add_data(8'h00, 1'b0);
    add_data(8'h00, 1'b0);
    add_data(8'h00, 1'b1);
    add_data(8'hff, 1'b1);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    cfg_open = 1'b0;
    foreach (script[k]) begin
      if (script[k].is_cfg) begin
        if (!cfg_open) settle();
        write_reg(script[k].addr, script[k].value);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) begin
          cfg.valid <= 1'b0;
          cfg_open = 1'b0;
        end
        send_item(script[k].b, script[k].l, script[k].typed, script[k].want);
      end
    end

    run_phase(0, 0, 80, 1'b0);
    run_phase(49, 0, 80, 1'b0);
    run_phase(0, 49, 80, 1'b0);
    run_phase(33, 33, 70, 1'b0);
    run_phase(0, 0, 30, 1'b1);

    settle();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_if.sv
hw/rtl/sfr_front.sv
hw/rtl/sfr_queue.sv
hw/rtl/sfr_back.sv
hw/rtl/stream_find_replace.sv
dv/tb_stream_find_replace.sv
